// File: rtl/bbrq_pkg.sv
`timescale 1ns / 1ps

package bbrq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int MAX_READERS_DEFAULT = 8;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_COMMIT  = 3'd1;
    localparam logic [2:0] REQ_TAKE    = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_CLOSE   = 3'd4;
    localparam logic [2:0] REQ_STATUS  = 3'd5;

    // Status codes returned with every result item.
    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_FULL   = 3'd1;
    localparam logic [2:0] STS_EMPTY  = 3'd2;
    localparam logic [2:0] STS_EOS    = 3'd3;
    localparam logic [2:0] STS_MISUSE = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DELIVERY_MODE = 2'd0;
    localparam logic [1:0] CFG_READER_COUNT  = 2'd1;
    localparam logic [1:0] CFG_WRITER_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] reader_id;
        logic [3:0] buffer_in;
    } req_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] buffer_out;
        logic       queue_empty;
        logic       queue_full;
        logic       stream_ended;
    } rsp_item_t;

endpackage

// File: rtl/broadcast_buffer_ring_queue.sv
`timescale 1ns / 1ps
// Channel  Handshake                    Payload
// req      req_valid / req_stall        req_item  (req_type, reader_id, buffer_in)
// rsp      rsp_valid / rsp_stall        rsp_item  (status, buffer_out, flags)
// cfg      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Each request is accepted in the idle state, where the slot memories are read;
// in the execute state the read data is used and written back.
// After reset a clearing pass loads each slot of the buffer memory with its own
// index; no request is accepted during it, configuration writes are.
// A result waiting under rsp_stall does not block the next acceptance; that
// request then waits in the execute state until the output register is free.

module broadcast_buffer_ring_queue #(
    parameter int DEPTH       = bbrq_pkg::DEPTH_DEFAULT,
    parameter int MAX_READERS = bbrq_pkg::MAX_READERS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bbrq_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bbrq_pkg::rsp_item_t rsp_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data
);

    localparam int PW = $clog2(2 * DEPTH);
    localparam int SW = $clog2(DEPTH);
    localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CW = $clog2(MAX_READERS + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(2 * DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= PW'(DEPTH)) ? p - PW'(DEPTH) : p;
        return s[SW-1:0];
    endfunction

    function automatic logic [PW:0] ptr_dist(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
        logic [PW:0] d;
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            d = {1'b0, a} + (PW + 1)'(2 * DEPTH) - {1'b0, b};
        end
        return d;
    endfunction

    function automatic logic [RW-1:0] rid_index(input logic [2:0] r);
        logic [RW+2:0] w;
        w = {{RW{1'b0}}, r};
        return w[RW-1:0];
    endfunction

    function automatic logic [CW-1:0] eff_readers(input logic [3:0] rc);
        int n;
        n = int'(rc);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_READERS)
        begin
            n = MAX_READERS;
        end
        return CW'(n);
    endfunction

    bbrq_pkg::state_t    state_reg, state_next;
    logic [SW-1:0]       clr_cnt_reg;
    bbrq_pkg::req_item_t req_q_reg;
    bbrq_pkg::rsp_item_t rsp_item_reg, rsp_item_next;
    logic                rsp_valid_reg;

    logic                mode_reg;
    logic [3:0]          rcount_reg;
    logic [3:0]          open_reg, open_next;
    logic                end_reg, end_next;

    logic [PW-1:0]       alloc_reg, alloc_next;
    logic [PW-1:0]       commit_reg, commit_next;
    logic [PW-1:0]       take_reg, take_next;
    logic [PW-1:0]       ret_reg, ret_next;
    logic [PW-1:0]       free_reg, free_next;
    logic [PW-1:0]       rd_ptr_reg [MAX_READERS];
    logic [PW-1:0]       rd_ptr_next;
    logic                rd_ptr_we;

    logic                accept;
    logic                exec_go;
    logic                clearing;

    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       buf_waddr, pend_waddr;
    logic [3:0]          buf_wdata;
    logic [CW-1:0]       pend_wdata;
    logic                buf_we, pend_we;
    logic [SW-1:0]       x_buf_waddr;
    logic [3:0]          x_buf_wdata;
    logic                x_buf_we;
    logic [3:0]          buf_rdata;
    logic [CW-1:0]       pend_rdata;
    logic [SW+3:0]       clr_ext;

    logic [RW-1:0]       q_rid;
    logic [PW-1:0]       rp_sel;
    logic [CW-1:0]       eff_n;
    logic                bcast;
    logic                rid_ok;
    logic                bin_bad;
    logic [CW-1:0]       pend_dec;
    logic [PW-1:0]       take_src;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbrq_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == SW'(DEPTH - 1))
                begin
                    state_next = bbrq_pkg::ST_IDLE;
                end
            end
            bbrq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bbrq_pkg::ST_EXEC;
                end
            end
            bbrq_pkg::ST_EXEC:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    state_next = bbrq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbrq_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        req_stall = 1'b1;
        exec_go   = 1'b0;
        clearing  = 1'b0;
        case (state_reg)
            bbrq_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            bbrq_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            bbrq_pkg::ST_EXEC:
            begin
                exec_go = !(rsp_valid_reg && rsp_stall);
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // Read address for the slot the incoming request will touch.
    always_comb
    begin
        case (req_item.req_type)
            bbrq_pkg::REQ_TAKE:
            begin
                rd_addr = mode_reg ? ptr_slot(rd_ptr_reg[rid_index(req_item.reader_id)])
                                   : ptr_slot(take_reg);
            end
            bbrq_pkg::REQ_RELEASE:
            begin
                rd_addr = ptr_slot(rd_ptr_reg[rid_index(req_item.reader_id)]);
            end
            default:
            begin
                rd_addr = ptr_slot(alloc_reg);
            end
        endcase
    end

    assign q_rid   = rid_index(req_q_reg.reader_id);
    assign rp_sel  = rd_ptr_reg[q_rid];
    assign eff_n   = eff_readers(rcount_reg);
    assign bcast   = mode_reg;
    assign rid_ok  = int'(req_q_reg.reader_id) < int'(eff_n);
    assign bin_bad = int'(req_q_reg.buffer_in) >= DEPTH;
    assign pend_dec = (pend_rdata != '0) ? pend_rdata - CW'(1) : '0;
    assign take_src = bcast ? rp_sel : take_reg;

    // Request execution, using the slot data read when the request was accepted.
    always_comb
    begin
        rsp_item_next        = '0;
        rsp_item_next.status = bbrq_pkg::STS_OK;
        alloc_next  = alloc_reg;
        commit_next = commit_reg;
        take_next   = take_reg;
        ret_next    = ret_reg;
        free_next   = free_reg;
        open_next   = open_reg;
        end_next    = end_reg;
        rd_ptr_next = rp_sel;
        rd_ptr_we   = 1'b0;
        x_buf_we    = 1'b0;
        x_buf_waddr = ptr_slot(commit_reg);
        x_buf_wdata = req_q_reg.buffer_in;
        pend_we     = 1'b0;
        pend_waddr  = ptr_slot(commit_reg);
        pend_wdata  = eff_n;

        case (req_q_reg.req_type)
            bbrq_pkg::REQ_ALLOC:
            begin
                if (ptr_dist(alloc_reg, free_reg) >= (PW + 1)'(DEPTH))
                begin
                    rsp_item_next.status = bbrq_pkg::STS_FULL;
                end
                else
                begin
                    rsp_item_next.buffer_out = buf_rdata;
                    alloc_next = ptr_inc(alloc_reg);
                end
            end
            bbrq_pkg::REQ_COMMIT:
            begin
                if (commit_reg == alloc_reg || bin_bad)
                begin
                    rsp_item_next.status = bbrq_pkg::STS_MISUSE;
                end
                else
                begin
                    x_buf_we    = 1'b1;
                    pend_we     = 1'b1;
                    commit_next = ptr_inc(commit_reg);
                end
            end
            bbrq_pkg::REQ_TAKE:
            begin
                if (bcast && !rid_ok)
                begin
                    rsp_item_next.status = bbrq_pkg::STS_MISUSE;
                end
                else if (take_src == commit_reg)
                begin
                    rsp_item_next.status = end_reg ? bbrq_pkg::STS_EOS
                                                   : bbrq_pkg::STS_EMPTY;
                end
                else
                begin
                    rsp_item_next.buffer_out = buf_rdata;
                    if (!bcast)
                    begin
                        take_next = ptr_inc(take_reg);
                    end
                end
            end
            bbrq_pkg::REQ_RELEASE:
            begin
                if (!bcast)
                begin
                    if (ret_reg == take_reg || bin_bad)
                    begin
                        rsp_item_next.status = bbrq_pkg::STS_MISUSE;
                    end
                    else
                    begin
                        x_buf_we    = 1'b1;
                        x_buf_waddr = ptr_slot(ret_reg);
                        ret_next    = ptr_inc(ret_reg);
                        free_next   = ptr_inc(ret_reg);
                    end
                end
                else if (!rid_ok || rp_sel == commit_reg)
                begin
                    rsp_item_next.status = bbrq_pkg::STS_MISUSE;
                end
                else
                begin
                    rd_ptr_we   = 1'b1;
                    rd_ptr_next = ptr_inc(rp_sel);
                    pend_we     = 1'b1;
                    pend_waddr  = ptr_slot(rp_sel);
                    pend_wdata  = pend_dec;
                    if (pend_dec == '0 && take_reg != commit_reg)
                    begin
                        take_next = ptr_inc(take_reg);
                        free_next = ptr_inc(free_reg);
                    end
                end
            end
            bbrq_pkg::REQ_CLOSE:
            begin
                if (open_reg == 4'd0)
                begin
                    rsp_item_next.status = bbrq_pkg::STS_MISUSE;
                end
                else
                begin
                    open_next = open_reg - 4'd1;
                    if (open_reg == 4'd1)
                    begin
                        end_next = 1'b1;
                    end
                end
            end
            bbrq_pkg::REQ_STATUS:
            begin
                rsp_item_next.status = bbrq_pkg::STS_OK;
            end
            default:
            begin
                rsp_item_next.status = bbrq_pkg::STS_MISUSE;
            end
        endcase

        rsp_item_next.queue_empty  = (take_next == commit_next);
        rsp_item_next.queue_full   = ptr_dist(alloc_next, free_next) >= (PW + 1)'(DEPTH);
        rsp_item_next.stream_ended = end_next && (take_next == commit_next);
    end

    // The clearing pass owns the buffer memory's write port until it ends.
    assign clr_ext   = {4'b0000, clr_cnt_reg};
    assign buf_we    = clearing || (exec_go && x_buf_we);
    assign buf_waddr = clearing ? clr_cnt_reg : x_buf_waddr;
    assign buf_wdata = clearing ? clr_ext[3:0] : x_buf_wdata;

    bbrq_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_slot_buffer (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (buf_rdata)
    );

    bbrq_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_slot_pending (
        .clk   (clk),
        .we    (exec_go && pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (pend_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_q_reg <= req_item;
        end
        if (exec_go)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbrq_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            rcount_reg    <= 4'd1;
            open_reg      <= 4'd1;
            end_reg       <= 1'b0;
            alloc_reg     <= '0;
            commit_reg    <= '0;
            take_reg      <= '0;
            ret_reg       <= '0;
            free_reg      <= '0;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                rd_ptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end

            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (exec_go)
            begin
                alloc_reg  <= alloc_next;
                commit_reg <= commit_next;
                take_reg   <= take_next;
                ret_reg    <= ret_next;
                free_reg   <= free_next;
                open_reg   <= open_next;
                end_reg    <= end_next;
                if (rd_ptr_we)
                begin
                    rd_ptr_reg[q_rid] <= rd_ptr_next;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bbrq_pkg::CFG_DELIVERY_MODE:
                    begin
                        mode_reg <= cfg_data[0];
                    end
                    bbrq_pkg::CFG_READER_COUNT:
                    begin
                        rcount_reg <= cfg_data;
                    end
                    bbrq_pkg::CFG_WRITER_COUNT:
                    begin
                        open_reg <= (cfg_data == 4'd0) ? 4'd1 : cfg_data;
                        end_reg  <= 1'b0;
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

`ifndef NO_ASSERTIONS
    // A stalled result item stays valid and unchanged until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |=> rsp_valid_reg && $stable(rsp_item_reg))
        else $error("stalled result item changed or was dropped");

    // A fresh result only ever comes out of the execute cycle.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == bbrq_pkg::ST_EXEC))
        else $error("result appeared without an executed request");

    // An accepted request always moves on to execution in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == bbrq_pkg::ST_EXEC)
        else $error("accepted request did not reach execution");
`endif

endmodule

// File: rtl/bbrq_ram.sv
`timescale 1ns / 1ps

module bbrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/sv/broadcast_buffer_ring_queue_tb.sv
`timescale 1ns / 1ps

module broadcast_buffer_ring_queue_tb;

    localparam int RING_DEPTH = bbrq_pkg::DEPTH_DEFAULT;
    localparam int READER_MAX = bbrq_pkg::MAX_READERS_DEFAULT;

    // Request codes that the block does not define.
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    typedef enum logic {
        ROW_REQUEST,
        ROW_SETTINGS
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        bbrq_pkg::req_item_t req;
        bit                  typed;
        bbrq_pkg::rsp_item_t want;
        logic [3:0]          mode;
        logic [3:0]          readers;
        logic [3:0]          writers;
    } plan_row_t;

    typedef struct {
        bbrq_pkg::rsp_item_t rsp;
        longint unsigned     pushed_at;
    } awaited_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    bbrq_pkg::req_item_t req_item;
    logic                rsp_valid;
    logic                rsp_stall;
    bbrq_pkg::rsp_item_t rsp_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [3:0]          cfg_data;

    // Shadow of the ring, its pointers and its registers.
    logic [3:0] slot_id    [RING_DEPTH];
    logic [3:0] slot_owed  [RING_DEPTH];
    logic [4:0] reader_pos [READER_MAX];
    logic [4:0] alloc_pos;
    logic [4:0] commit_pos;
    logic [4:0] take_pos;
    logic [4:0] return_pos;
    logic [4:0] free_pos;
    logic [3:0] writers_open;
    logic       eos_seen;
    logic       mode_bcast;
    logic [3:0] readers_cfg;

    awaited_t awaited_results[$];
    int       fails;
    bit       calm;

    broadcast_buffer_ring_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [3:0] reader_limit();
        if (readers_cfg == 4'd0)
            return 4'd1;
        if (readers_cfg > 4'(READER_MAX))
            return 4'(READER_MAX);
        return readers_cfg;
    endfunction

    function automatic bit ring_full();
        return 5'(alloc_pos - free_pos) >= 5'(RING_DEPTH);
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [3:0] value);
        case (idx)
            bbrq_pkg::CFG_DELIVERY_MODE: mode_bcast = value[0];
            bbrq_pkg::CFG_READER_COUNT:  readers_cfg = value;
            bbrq_pkg::CFG_WRITER_COUNT:
            begin
                writers_open = (value == 4'd0) ? 4'd1 : value;
                eos_seen = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic bbrq_pkg::rsp_item_t serve_request(input bbrq_pkg::req_item_t r);
        bbrq_pkg::rsp_item_t o;
        logic [4:0]          p;
        logic [3:0]          s;
        logic [3:0]          nrd;
        logic                rid_ok;
        nrd = reader_limit();
        rid_ok = {1'b0, r.reader_id} < nrd;
        o = '0;
        o.status = bbrq_pkg::STS_OK;
        case (r.req_type)
            bbrq_pkg::REQ_ALLOC:
            begin
                if (ring_full())
                    o.status = bbrq_pkg::STS_FULL;
                else
                begin
                    o.buffer_out = slot_id[alloc_pos[3:0]];
                    alloc_pos = alloc_pos + 5'd1;
                end
            end
            bbrq_pkg::REQ_COMMIT:
            begin
                if (commit_pos == alloc_pos)
                    o.status = bbrq_pkg::STS_MISUSE;
                else
                begin
                    slot_id[commit_pos[3:0]] = r.buffer_in;
                    slot_owed[commit_pos[3:0]] = nrd;
                    commit_pos = commit_pos + 5'd1;
                end
            end
            bbrq_pkg::REQ_TAKE:
            begin
                if (mode_bcast && !rid_ok)
                    o.status = bbrq_pkg::STS_MISUSE;
                else
                begin
                    p = mode_bcast ? reader_pos[r.reader_id] : take_pos;
                    if (p == commit_pos)
                        o.status = eos_seen ? bbrq_pkg::STS_EOS : bbrq_pkg::STS_EMPTY;
                    else
                    begin
                        o.buffer_out = slot_id[p[3:0]];
                        if (!mode_bcast)
                            take_pos = take_pos + 5'd1;
                    end
                end
            end
            bbrq_pkg::REQ_RELEASE:
            begin
                if (!mode_bcast)
                begin
                    if (return_pos == take_pos)
                        o.status = bbrq_pkg::STS_MISUSE;
                    else
                    begin
                        slot_id[return_pos[3:0]] = r.buffer_in;
                        return_pos = return_pos + 5'd1;
                        free_pos = return_pos;
                    end
                end
                else if (!rid_ok || reader_pos[r.reader_id] == commit_pos)
                    o.status = bbrq_pkg::STS_MISUSE;
                else
                begin
                    s = reader_pos[r.reader_id][3:0];
                    reader_pos[r.reader_id] = reader_pos[r.reader_id] + 5'd1;
                    // A count that is already zero stays there and still frees the slot.
                    if (slot_owed[s] != 4'd0)
                        slot_owed[s] = slot_owed[s] - 4'd1;
                    if (slot_owed[s] == 4'd0 && take_pos != commit_pos)
                    begin
                        take_pos = take_pos + 5'd1;
                        free_pos = free_pos + 5'd1;
                    end
                end
            end
            bbrq_pkg::REQ_CLOSE:
            begin
                if (writers_open == 4'd0)
                    o.status = bbrq_pkg::STS_MISUSE;
                else
                begin
                    writers_open = writers_open - 4'd1;
                    if (writers_open == 4'd0)
                        eos_seen = 1'b1;
                end
            end
            bbrq_pkg::REQ_STATUS: ;
            default: o.status = bbrq_pkg::STS_MISUSE;
        endcase
        o.queue_empty = take_pos == commit_pos;
        o.queue_full = ring_full();
        o.stream_ended = eos_seen && o.queue_empty;
        return o;
    endfunction

    // Mostly well-formed traffic: commits hand back the buffer that was allocated
    // and releases the buffer that was taken, so the ring keeps a true set of ids.
    function automatic bbrq_pkg::req_item_t pick_request(input bit writer_heavy);
        bbrq_pkg::req_item_t r;
        int                  roll;
        logic [3:0]          nrd;
        nrd = reader_limit();
        r.req_type = bbrq_pkg::REQ_STATUS;
        r.reader_id = 3'($urandom);
        r.buffer_in = 4'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 12)
            r.req_type = 3'($urandom);
        else if (roll < 15)
            r.req_type = bbrq_pkg::REQ_CLOSE;
        else if (roll < 18)
            r.req_type = bbrq_pkg::REQ_STATUS;
        else if ($urandom_range(0, 99) < (writer_heavy ? 70 : 45))
        begin
            if (commit_pos != alloc_pos && $urandom_range(0, 1) == 1)
            begin
                r.req_type = bbrq_pkg::REQ_COMMIT;
                r.buffer_in = slot_id[commit_pos[3:0]];
            end
            else
                r.req_type = bbrq_pkg::REQ_ALLOC;
        end
        else if (mode_bcast)
        begin
            r.reader_id = 3'($urandom_range(0, int'(nrd) - 1));
            if (reader_pos[r.reader_id] != commit_pos && $urandom_range(0, 1) == 1)
                r.req_type = bbrq_pkg::REQ_RELEASE;
            else
                r.req_type = bbrq_pkg::REQ_TAKE;
        end
        else if (return_pos != take_pos && $urandom_range(0, 1) == 1)
        begin
            r.req_type = bbrq_pkg::REQ_RELEASE;
            r.buffer_in = slot_id[return_pos[3:0]];
        end
        else
            r.req_type = bbrq_pkg::REQ_TAKE;
        return r;
    endfunction

    function automatic plan_row_t ask(input logic [2:0] t, input logic [2:0] rid,
                                      input logic [3:0] bin);
        plan_row_t row;
        row.kind = ROW_REQUEST;
        row.req = '{t, rid, bin};
        row.typed = 1'b0;
        row.want = '0;
        row.mode = '0;
        row.readers = '0;
        row.writers = '0;
        return row;
    endfunction

    function automatic plan_row_t ask_known(input logic [2:0] t, input logic [2:0] rid,
                                            input logic [3:0] bin, input logic [2:0] st,
                                            input logic [3:0] bout, input logic e,
                                            input logic f, input logic ended);
        plan_row_t row;
        row = ask(t, rid, bin);
        row.typed = 1'b1;
        row.want = '{st, bout, e, f, ended};
        return row;
    endfunction

    function automatic plan_row_t settings_row(input logic [3:0] m, input logic [3:0] rd,
                                               input logic [3:0] wr);
        plan_row_t row;
        row = ask(bbrq_pkg::REQ_STATUS, 3'd0, 4'd0);
        row.kind = ROW_SETTINGS;
        row.mode = m;
        row.readers = rd;
        row.writers = wr;
        return row;
    endfunction

    task automatic send_request(input bbrq_pkg::req_item_t r, input bit typed,
                                input bbrq_pkg::rsp_item_t want);
        awaited_t            a;
        bbrq_pkg::rsp_item_t predicted;
        req_valid <= 1'b1;
        req_item <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = serve_request(r);
        a.rsp = typed ? want : predicted;
        a.pushed_at = $time;
        awaited_results.push_back(a);
    endtask

    task automatic pause_sender();
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic go_quiet();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic write_settings(input logic [3:0] m, input logic [3:0] rd,
                                  input logic [3:0] wr);
        logic [1:0] regs [3];
        logic [3:0] vals [3];
        regs = '{bbrq_pkg::CFG_DELIVERY_MODE, bbrq_pkg::CFG_READER_COUNT,
                 bbrq_pkg::CFG_WRITER_COUNT};
        vals = '{m, rd, wr};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            apply_register(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string field, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endtask

    initial
    begin
        awaited_t a;
        rsp_stall <= 1'b0;
        fails = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
            begin
                // An expectation pushed at this very edge cannot belong to this item.
                if (awaited_results.size() == 0 || awaited_results[0].pushed_at == $time)
                begin
                    $display("%0t ns: unexpected result item: expected none, got %p",
                             $time, rsp_item);
                    fails++;
                end
                else
                begin
                    a = awaited_results.pop_front();
                    compare_field("status", 4'(a.rsp.status), 4'(rsp_item.status));
                    compare_field("buffer_out", a.rsp.buffer_out, rsp_item.buffer_out);
                    compare_field("queue_empty", 4'(a.rsp.queue_empty),
                                  4'(rsp_item.queue_empty));
                    compare_field("queue_full", 4'(a.rsp.queue_full), 4'(rsp_item.queue_full));
                    compare_field("stream_ended", 4'(a.rsp.stream_ended),
                                  4'(rsp_item.stream_ended));
                end
            end
            rsp_stall <= !calm && $urandom_range(0, 99) < 25;
        end
    end

    initial
    begin
        plan_row_t  plan[$];
        logic [3:0] mode_v;
        logic [3:0] readers_v;
        logic [3:0] writers_v;
        bit         writer_heavy;

        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        calm = 1'b0;

        for (int i = 0; i < RING_DEPTH; i++)
        begin
            slot_id[i] = 4'(i);
            slot_owed[i] = 4'd0;
        end
        for (int i = 0; i < READER_MAX; i++)
            reader_pos[i] = 5'd0;
        alloc_pos = 5'd0;
        commit_pos = 5'd0;
        take_pos = 5'd0;
        return_pos = 5'd0;
        free_pos = 5'd0;
        mode_bcast = 1'b0;
        readers_cfg = 4'd1;
        writers_open = 4'd1;
        eos_seen = 1'b0;

        // Empty ring, misuse on an empty ring, one full round trip, then end of stream.
        plan.push_back(ask_known(bbrq_pkg::REQ_TAKE, 3'd7, 4'd15,
                                 bbrq_pkg::STS_EMPTY, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_RELEASE, 3'd0, 4'd0,
                                 bbrq_pkg::STS_MISUSE, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_COMMIT, 3'd0, 4'd5,
                                 bbrq_pkg::STS_MISUSE, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_STATUS, 3'd3, 4'd9,
                                 bbrq_pkg::STS_OK, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(REQ_SPARE_A, 3'd0, 4'd0,
                                 bbrq_pkg::STS_MISUSE, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(REQ_SPARE_B, 3'd7, 4'd15,
                                 bbrq_pkg::STS_MISUSE, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_ALLOC, 3'd0, 4'd0,
                                 bbrq_pkg::STS_OK, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_COMMIT, 3'd0, 4'd15,
                                 bbrq_pkg::STS_OK, 4'd0, 0, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_TAKE, 3'd0, 4'd0,
                                 bbrq_pkg::STS_OK, 4'd15, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_RELEASE, 3'd5, 4'd15,
                                 bbrq_pkg::STS_OK, 4'd0, 1, 0, 0));
        plan.push_back(ask_known(bbrq_pkg::REQ_CLOSE, 3'd0, 4'd0,
                                 bbrq_pkg::STS_OK, 4'd0, 1, 0, 1));
        plan.push_back(ask_known(bbrq_pkg::REQ_CLOSE, 3'd0, 4'd0,
                                 bbrq_pkg::STS_MISUSE, 4'd0, 1, 0, 1));
        plan.push_back(ask_known(bbrq_pkg::REQ_TAKE, 3'd2, 4'd0,
                                 bbrq_pkg::STS_EOS, 4'd0, 1, 0, 1));
        plan.push_back(ask_known(bbrq_pkg::REQ_ALLOC, 3'd0, 4'd0,
                                 bbrq_pkg::STS_OK, 4'd1, 1, 0, 1));
        // Broadcast with a clamped reader count and a zero writer count.
        plan.push_back(settings_row(4'd1, 4'd15, 4'd0));
        plan.push_back(ask_known(bbrq_pkg::REQ_COMMIT, 3'd0, 4'd9,
                                 bbrq_pkg::STS_OK, 4'd0, 0, 0, 0));
        plan.push_back(ask(bbrq_pkg::REQ_TAKE, 3'd7, 4'd0));
        plan.push_back(ask(bbrq_pkg::REQ_RELEASE, 3'd7, 4'd3));
        plan.push_back(ask(bbrq_pkg::REQ_TAKE, 3'd7, 4'd0));
        // A single reader: reader ids above zero are misuse, and a drained count stays zero.
        plan.push_back(settings_row(4'd1, 4'd1, 4'd8));
        plan.push_back(ask(bbrq_pkg::REQ_TAKE, 3'd7, 4'd0));
        plan.push_back(ask(bbrq_pkg::REQ_RELEASE, 3'd0, 4'd0));
        plan.push_back(ask(bbrq_pkg::REQ_RELEASE, 3'd7, 4'd0));
        plan.push_back(ask(bbrq_pkg::REQ_CLOSE, 3'd0, 4'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_SETTINGS)
            begin
                go_quiet();
                write_settings(plan[n].mode, plan[n].readers, plan[n].writers);
            end
            else
            begin
                pause_sender();
                send_request(plan[n].req, plan[n].typed, plan[n].want);
            end
        end

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: begin mode_v = 4'd0; readers_v = 4'd1;  writers_v = 4'd1;  end
                1: begin mode_v = 4'd1; readers_v = 4'd8;  writers_v = 4'd8;  end
                2: begin mode_v = 4'd1; readers_v = 4'd0;  writers_v = 4'd15; end
                3: begin mode_v = 4'd0; readers_v = 4'd15; writers_v = 4'd0;  end
                4: begin mode_v = 4'd1; readers_v = 4'd1;  writers_v = 4'd2;  end
                default:
                begin
                    mode_v = 4'($urandom);
                    readers_v = 4'($urandom);
                    writers_v = 4'($urandom_range(0, 4));
                end
            endcase
            writer_heavy = $urandom_range(0, 2) == 0;
            go_quiet();
            calm = phase == 5;
            write_settings(mode_v, readers_v, writers_v);
            for (int k = 0; k < 100; k++)
            begin
                pause_sender();
                send_request(pick_request(writer_heavy), 1'b0, '0);
            end
        end

        go_quiet();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
